// File: rtl/prme_pkg.sv
// prme_pkg: shared types and constants of the piano-roll midi event encoder
// used by every file in rtl/, depends on nothing
`timescale 1ns / 1ps

package prme_pkg;

    // request codes of the input item
    localparam logic [1:0] REQ_CELL    = 2'd0;
    localparam logic [1:0] REQ_STEP    = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_ON_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_NOTE_OFFSET  = 2'd1;
    localparam logic [1:0] REG_ON_VELOCITY  = 2'd2;
    localparam logic [1:0] REG_MIDI_CHANNEL = 2'd3;

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 8;

    // reset values of the configuration registers
    localparam logic [7:0] RST_ON_THRESHOLD = 8'd229;
    localparam logic [5:0] RST_NOTE_OFFSET  = 6'd20;
    localparam logic [6:0] RST_ON_VELOCITY  = 7'd64;
    localparam logic [3:0] RST_MIDI_CHANNEL = 4'd0;

    localparam int DELTA_W = 14;
    localparam logic [DELTA_W-1:0] DELTA_MAX = 14'h3FFF;

    localparam int KEY_W  = 7;
    localparam int NOTE_W = 7;
    localparam int VEL_W  = 7;
    localparam int CHAN_W = 4;

    // high nibble of the note-on status byte
    localparam logic [3:0] STATUS_NOTE_ON_HI = 4'h9;

    // event queue between front and back
    localparam int EVQ_DEPTH = 4;
    localparam int EVQ_AW    = 2;
    localparam int EVQ_CW    = 3;

    // one note event, ready to be serialized
    typedef struct packed {
        logic [DELTA_W-1:0] delta;
        logic               first;
        logic [CHAN_W-1:0]  channel;
        logic [NOTE_W-1:0]  note;
        logic [VEL_W-1:0]   velocity;
    } t_event;

    // queue status, used to gate the front's input and seen by the back
    typedef struct packed {
        logic             full;
        logic             avail;
        logic [EVQ_CW-1:0] count;
    } t_evq_stat;

endpackage

// File: rtl/piano_roll_midi_event_encoder.sv
// piano_roll_midi_event_encoder: top level, front + event queue + byte back end
// depends on prme_pkg, prme_front, prme_evq, prme_back
`timescale 1ns / 1ps

// Turns a piano-roll item stream into running-status MIDI note event bytes.
// Items enter through push/full; an item is taken in the cycle it is pushed
// while the four-entry event queue has room, so step-end and no-change items
// stream at one per cycle. A key whose held state flips yields one event of
// three to five bytes (delta as one or two VLQ bytes, the 0x9n status byte on
// the first event only, note, velocity with last set); the back end sends one
// byte per cycle from its output register while bytes are popped, and its
// byte rate sets the sustained event rate. Note offs go out as velocity
// zero. Configuration is captured into each event when it is classified, so
// writes must be made while the block is idle.

module piano_roll_midi_event_encoder #(
    parameter int NUM_KEYS = 96
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input queue side
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  i_req_type,
    input  logic [6:0]                  i_key,
    input  logic [7:0]                  i_note_level,
    // result queue side
    output logic                        empty,
    input  logic                        pop,
    output logic [7:0]                  o_out_byte,
    output logic                        o_last,
    // configuration writes
    input  logic                        i_cfg_we,
    input  logic [prme_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [prme_pkg::CFG_DW-1:0] i_cfg_data
);

    // input transfer: front classifies and may push one event
    logic                accept;
    logic                ev_push;
    prme_pkg::t_event    ev_in;
    prme_pkg::t_event    ev_head;
    prme_pkg::t_evq_stat evq_stat;
    logic                ev_pop;
    logic                out_valid;

    // the front never pushes into a full queue, so full blocks every item
    assign full   = evq_stat.full;
    assign accept = push && !full;
    assign empty  = !out_valid;

    prme_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_req_type   (i_req_type),
        .i_key        (i_key),
        .i_note_level (i_note_level),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_ev_push    (ev_push),
        .o_ev         (ev_in)
    );

    // decouples classification from byte serialization
    prme_evq u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ev_push),
        .i_ev    (ev_in),
        .i_pop   (ev_pop),
        .o_head  (ev_head),
        .o_stat  (evq_stat)
    );

    // one byte per cycle into the output register, refilled on a result transfer
    prme_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev       (ev_head),
        .i_ev_avail (evq_stat.avail),
        .i_pop      (pop),
        .o_ev_pop   (ev_pop),
        .o_valid    (out_valid),
        .o_byte     (o_out_byte),
        .o_last     (o_last)
    );

    // the closing byte of an event is always a 7-bit velocity
    a_last_is_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last) |-> !o_out_byte[7])
        else $error("last byte has bit 7 set");

    // queue occupancy stays within its depth
    a_evq_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        evq_stat.count <= prme_pkg::EVQ_CW'(prme_pkg::EVQ_DEPTH))
        else $error("event queue overfilled");

    // output bytes come only from queued events
    a_no_phantom : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !evq_stat.avail) |=> empty)
        else $error("byte produced without a queued event");

    // an event is dequeued only together with its final byte
    a_pop_on_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ev_pop |=> (!empty && o_last))
        else $error("event dequeued without its last byte");

endmodule

// File: rtl/prme_front.sv
// prme_front: takes input items, keeps held keys, delta counter and config
// depends on prme_pkg
`timescale 1ns / 1ps

module prme_front #(
    parameter int NUM_KEYS = 96
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [1:0]                  i_req_type,
    input  logic [prme_pkg::KEY_W-1:0]  i_key,
    input  logic [7:0]                  i_note_level,
    input  logic                        i_cfg_we,
    input  logic [prme_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [prme_pkg::CFG_DW-1:0] i_cfg_data,
    output logic                        o_ev_push,
    output prme_pkg::t_event            o_ev
);

    localparam int KEY_IW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [prme_pkg::KEY_W:0] KEY_LIMIT = (prme_pkg::KEY_W + 1)'(NUM_KEYS);

    logic [7:0]                     r_on_threshold;
    logic [5:0]                     r_note_offset;
    logic [prme_pkg::VEL_W-1:0]     r_on_velocity;
    logic [prme_pkg::CHAN_W-1:0]    r_midi_channel;
    logic [NUM_KEYS-1:0]            r_held;
    logic [prme_pkg::DELTA_W-1:0]   r_delta;
    logic                           r_first;

    logic [NUM_KEYS-1:0]            n_held;
    logic [prme_pkg::DELTA_W-1:0]   n_delta;
    logic                           n_first;

    logic              key_ok;
    logic [KEY_IW-1:0] key_idx;
    logic              held_now;
    logic              want;
    logic              fire;
    logic              fire_on;

    assign key_ok   = {1'b0, i_key} < KEY_LIMIT;
    assign key_idx  = i_key[KEY_IW-1:0];
    assign held_now = r_held[key_idx];
    assign want     = i_note_level > r_on_threshold;

    always_comb begin
        fire    = 1'b0;
        fire_on = 1'b0;
        n_held  = r_held;
        n_delta = r_delta;
        n_first = r_first;
        if (i_accept) begin
            unique case (i_req_type)
                prme_pkg::REQ_CELL: begin
                    if (key_ok && (want != held_now)) begin
                        fire            = 1'b1;
                        fire_on         = want;
                        n_held[key_idx] = want;
                    end
                end
                prme_pkg::REQ_STEP: begin
                    if (r_delta != prme_pkg::DELTA_MAX) begin
                        n_delta = r_delta + 1'b1;
                    end
                end
                prme_pkg::REQ_RELEASE: begin
                    if (key_ok && held_now) begin
                        fire            = 1'b1;
                        n_held[key_idx] = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
        if (fire) begin
            n_delta = '0;
            n_first = 1'b0;
        end
    end

    assign o_ev_push      = fire;
    assign o_ev.delta     = r_delta;
    assign o_ev.first     = r_first;
    assign o_ev.channel   = r_midi_channel;
    assign o_ev.note      = prme_pkg::NOTE_W'(i_key + prme_pkg::KEY_W'(r_note_offset));
    assign o_ev.velocity  = fire_on ? r_on_velocity : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held         <= '0;
            r_delta        <= '0;
            r_first        <= 1'b1;
            r_on_threshold <= prme_pkg::RST_ON_THRESHOLD;
            r_note_offset  <= prme_pkg::RST_NOTE_OFFSET;
            r_on_velocity  <= prme_pkg::RST_ON_VELOCITY;
            r_midi_channel <= prme_pkg::RST_MIDI_CHANNEL;
        end else begin
            r_held  <= n_held;
            r_delta <= n_delta;
            r_first <= n_first;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    prme_pkg::REG_ON_THRESHOLD: r_on_threshold <= i_cfg_data;
                    prme_pkg::REG_NOTE_OFFSET:  r_note_offset  <= i_cfg_data[5:0];
                    prme_pkg::REG_ON_VELOCITY:  r_on_velocity  <= i_cfg_data[6:0];
                    prme_pkg::REG_MIDI_CHANNEL: r_midi_channel <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// File: rtl/prme_evq.sv
// prme_evq: small fifo of note events between front and back
// depends on prme_pkg
`timescale 1ns / 1ps

module prme_evq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  prme_pkg::t_event    i_ev,
    input  logic                i_pop,
    output prme_pkg::t_event    o_head,
    output prme_pkg::t_evq_stat o_stat
);

    prme_pkg::t_event                r_slot [prme_pkg::EVQ_DEPTH];
    logic [prme_pkg::EVQ_AW-1:0]     r_wr;
    logic [prme_pkg::EVQ_AW-1:0]     r_rd;
    logic [prme_pkg::EVQ_CW-1:0]     r_count;

    logic do_push;
    logic do_pop;

    assign o_stat.full  = r_count == prme_pkg::EVQ_CW'(prme_pkg::EVQ_DEPTH);
    assign o_stat.avail = r_count != '0;
    assign o_stat.count = r_count;
    assign o_head       = r_slot[r_rd];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && o_stat.avail;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/prme_back.sv
// prme_back: serializes queued note events into bytes behind an output register
// depends on prme_pkg
`timescale 1ns / 1ps

module prme_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  prme_pkg::t_event i_ev,
    input  logic             i_ev_avail,
    input  logic             i_pop,
    output logic             o_ev_pop,
    output logic             o_valid,
    output logic [7:0]       o_byte,
    output logic             o_last
);

    typedef enum logic [2:0] {
        STEP_DHI,
        STEP_DLO,
        STEP_STATUS,
        STEP_NOTE,
        STEP_VEL
    } t_step_e;

    t_step_e    r_step;
    logic       r_mid;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    t_step_e    cur_step;
    t_step_e    n_step;
    logic [7:0] n_byte;
    logic       adv;

    always_comb begin
        if (r_mid) begin
            cur_step = r_step;
        end else if (i_ev.delta[prme_pkg::DELTA_W-1:7] != '0) begin
            cur_step = STEP_DHI;
        end else begin
            cur_step = STEP_DLO;
        end
    end

    always_comb begin
        unique case (cur_step)
            STEP_DHI: begin
                n_byte = {1'b1, i_ev.delta[prme_pkg::DELTA_W-1:7]};
                n_step = STEP_DLO;
            end
            STEP_DLO: begin
                n_byte = {1'b0, i_ev.delta[6:0]};
                n_step = i_ev.first ? STEP_STATUS : STEP_NOTE;
            end
            STEP_STATUS: begin
                n_byte = {prme_pkg::STATUS_NOTE_ON_HI, i_ev.channel};
                n_step = STEP_NOTE;
            end
            STEP_NOTE: begin
                n_byte = {1'b0, i_ev.note};
                n_step = STEP_VEL;
            end
            STEP_VEL: begin
                n_byte = {1'b0, i_ev.velocity};
                n_step = STEP_DLO;
            end
            default: begin
                n_byte = '0;
                n_step = STEP_DLO;
            end
        endcase
    end

    assign adv      = i_ev_avail && (!r_valid || i_pop);
    assign o_ev_pop = adv && (cur_step == STEP_VEL);
    assign o_valid  = r_valid;
    assign o_byte   = r_byte;
    assign o_last   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_DLO;
            r_mid   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_valid <= 1'b1;
                r_byte  <= n_byte;
                r_last  <= cur_step == STEP_VEL;
                r_mid   <= cur_step != STEP_VEL;
                r_step  <= n_step;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule
